// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define AST_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off while rst is high.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== hw/rtl/ahrl_pkg.sv =====
// Shared types and constants of the adaptive hedging rate limiter.
package ahrl_pkg;

  localparam int AmountW = 16;
  localparam int TimeW   = 40;
  localparam int DelayW  = 32;
  localparam int CntW    = 32;
  localparam int RatioW  = 17;
  localparam int TuneW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 32;

  localparam int DivNumW = 64;
  localparam int DivDenW = 32;
  localparam int DivSteps = DivNumW;
  localparam int DivCntW = $clog2(DivSteps);

  localparam logic [RatioW-1:0] RatioOne        = RatioW'(65536);
  localparam logic [RatioW-1:0] RatioReset      = RatioW'(6554);
  localparam logic [31:0]       TickReset       = 32'd1000000;
  localparam logic [TuneW-1:0]  TuneReset       = TuneW'(320);
  localparam logic [TuneW-1:0]  TuneUnity       = TuneW'(256);
  localparam logic [DelayW-1:0] MinDelayReset   = '0;
  localparam logic [DelayW-1:0] MaxDelayReset   = DelayW'(100000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_BACKUP_RATIO = 3'd0,
    REG_TICK_PERIOD  = 3'd1,
    REG_TUNE_FACTOR  = 3'd2,
    REG_MIN_DELAY    = 3'd3,
    REG_MAX_DELAY    = 3'd4
  } ahrl_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_ROLL_MUL,
    S_ROLL_DEC,
    S_ROLL_WAIT,
    S_ROLL_COMMIT,
    S_ACT,
    S_WB_MUL,
    S_WB_DIV,
    S_WB_WAIT,
    S_WP_MUL,
    S_WP_DIV,
    S_WP_WAIT,
    S_LIM_SUM,
    S_LIM_MUL,
    S_LIM_DEC,
    S_OUT
  } ahrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic bypass_res;
    logic roll_mul;
    logic roll_dec;
    logic roll_div_cap;
    logic roll_commit;
    logic act;
    logic w_mul;
    logic w_sel;      // 0: backups, 1: primaries
    logic w_cap;
    logic div_start;
    logic div_sel;    // 0: delay retune, 1: window weight
    logic lim_sum;
    logic lim_mul;
    logic lim_dec;
    logic load_out;
  } ahrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bypass;
    logic roll_needed;
    logic roll_up;
    logic act1;
    logic wt_zero;
    logic div_done;
    logic out_free;
  } ahrl_stat_t;

endpackage

// ===== hw/rtl/ahrl_if.sv =====
// Valid/ready channel interfaces: request, response and register write.
interface ahrl_in_if;
  import ahrl_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [AmountW-1:0] amount;
  logic [TimeW-1:0]   now_us;
  modport source (output valid, action, amount, now_us, input ready);
  modport sink   (input valid, action, amount, now_us, output ready);
endinterface

interface ahrl_out_if;
  import ahrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [DelayW-1:0] delay_us;
  logic              approved;
  modport source (output valid, delay_us, approved, input ready);
  modport sink   (input valid, delay_us, approved, output ready);
endinterface

interface ahrl_cfg_if;
  import ahrl_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/adaptive_hedging_rate_limiter.sv =====
// Top level of the adaptive hedging rate limiter: sequencer plus datapath.
//
//   channel  dir  payload                          word accepted when
//   req      in   action, amount, now_us           req.valid && req.ready
//   rsp      out  delay_us, approved               rsp.valid && rsp.ready
//   cfg      in   index, data                      cfg.valid (ready always high)
//
// One word at a time. Action 0 runs check, act and result load; action 1 adds
// limit sum, multiply and decision; bypass skips to result. A window roll adds
// multiply, decide and commit, plus a 64-step shared divider pass if the delay
// shrinks. Action 1 adds two weighting divisions unless the window has fully
// aged. req.ready rises again once the result is loaded; a stalled rsp holds
// its word and blocks only the next load. Synchronous reset, no clearing pass.
module adaptive_hedging_rate_limiter (
  input  logic        clk,
  input  logic        rst,
  ahrl_in_if.sink     req,
  ahrl_out_if.source  rsp,
  ahrl_cfg_if.sink    cfg
);
  import ahrl_pkg::*;

  ahrl_cmd_t  cmd;
  ahrl_stat_t stat;

  assign cfg.ready = 1'b1;

  ahrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ahrl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_action    (req.action),
    .in_amount    (req.amount),
    .in_now_us    (req.now_us),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_delay_us (rsp.delay_us),
    .out_approved (rsp.approved)
  );

endmodule

// ===== hw/rtl/ahrl_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module ahrl_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ahrl_pkg::DivNumW-1:0] dividend,
  input  logic [ahrl_pkg::DivDenW-1:0] divisor,
  output logic                         done,
  output logic [ahrl_pkg::DivNumW-1:0] quotient
);
  import ahrl_pkg::*;

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [DivNumW-1:0] dq;
  logic [DivDenW-1:0] rem;
  logic [DivDenW-1:0] dvs;
  logic [DivDenW:0]   rem_sh;
  logic               qbit;

  assign rem_sh   = {rem, dq[DivNumW-1]};
  assign qbit     = rem_sh >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DivCntW'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[DivNumW-2:0], qbit};
      rem <= qbit ? DivDenW'(rem_sh - {1'b0, dvs}) : rem_sh[DivDenW-1:0];
    end
  end

endmodule

// ===== hw/rtl/ahrl_ctrl.sv =====
// Sequencer: steps one word through check, window roll, weighting and limit test.
module ahrl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output ahrl_pkg::ahrl_cmd_t    cmd,
  input  ahrl_pkg::ahrl_stat_t   stat
);
  import ahrl_pkg::*;

  ahrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:        if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (stat.bypass)           state_next = S_OUT;
        else if (stat.roll_needed) state_next = S_ROLL_MUL;
        else                       state_next = S_ACT;
      end
      S_ROLL_MUL:    state_next = S_ROLL_DEC;
      S_ROLL_DEC:    state_next = stat.roll_up ? S_ROLL_COMMIT : S_ROLL_WAIT;
      S_ROLL_WAIT:   if (stat.div_done) state_next = S_ROLL_COMMIT;
      S_ROLL_COMMIT: state_next = S_ACT;
      S_ACT: begin
        if (!stat.act1)        state_next = S_OUT;
        else if (stat.wt_zero) state_next = S_LIM_SUM;
        else                   state_next = S_WB_MUL;
      end
      S_WB_MUL:      state_next = S_WB_DIV;
      S_WB_DIV:      state_next = S_WB_WAIT;
      S_WB_WAIT:     if (stat.div_done) state_next = S_WP_MUL;
      S_WP_MUL:      state_next = S_WP_DIV;
      S_WP_DIV:      state_next = S_WP_WAIT;
      S_WP_WAIT:     if (stat.div_done) state_next = S_LIM_SUM;
      S_LIM_SUM:     state_next = S_LIM_MUL;
      S_LIM_MUL:     state_next = S_LIM_DEC;
      S_LIM_DEC:     state_next = S_OUT;
      S_OUT:         if (stat.out_free) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_CHECK:       cmd.bypass_res = stat.bypass;
      S_ROLL_MUL:    cmd.roll_mul = 1'b1;
      S_ROLL_DEC: begin
        cmd.roll_dec  = stat.roll_up;
        cmd.div_start = !stat.roll_up;
        cmd.div_sel   = 1'b0;
      end
      S_ROLL_WAIT:   cmd.roll_div_cap = stat.div_done;
      S_ROLL_COMMIT: cmd.roll_commit = 1'b1;
      S_ACT:         cmd.act = 1'b1;
      S_WB_MUL:      cmd.w_mul = 1'b1;
      S_WB_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      S_WB_WAIT:     cmd.w_cap = stat.div_done;
      S_WP_MUL: begin
        cmd.w_mul = 1'b1;
        cmd.w_sel = 1'b1;
      end
      S_WP_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      S_WP_WAIT: begin
        cmd.w_cap = stat.div_done;
        cmd.w_sel = 1'b1;
      end
      S_LIM_SUM:     cmd.lim_sum = 1'b1;
      S_LIM_MUL:     cmd.lim_mul = 1'b1;
      S_LIM_DEC:     cmd.lim_dec = 1'b1;
      S_OUT:         cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ahrl_dp.sv =====
// Datapath: registers, window counters, multipliers, clamp and output register.
module ahrl_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ahrl_pkg::ahrl_cmd_t           cmd,
  output ahrl_pkg::ahrl_stat_t          stat,
  input  logic                          in_action,
  input  logic [ahrl_pkg::AmountW-1:0]  in_amount,
  input  logic [ahrl_pkg::TimeW-1:0]    in_now_us,
  input  logic                          cfg_valid,
  input  logic [ahrl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ahrl_pkg::CfgDatW-1:0]  cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ahrl_pkg::DelayW-1:0]   out_delay_us,
  output logic                          out_approved
);
  import ahrl_pkg::*;

  // configuration
  logic [RatioW-1:0] ratio;
  logic [31:0]       tick;
  logic [TuneW-1:0]  tune;
  logic [DelayW-1:0] min_d;
  logic [DelayW-1:0] max_d;

  // window state
  logic [TimeW-1:0]  window_start;
  logic [DelayW-1:0] cur_delay;
  logic [CntW-1:0]   prim_now, att_now, bak_now, prim_bef, bak_bef;

  // current word and scratch
  logic               act_r;
  logic [AmountW-1:0] amt_r;
  logic [TimeW-1:0]   now_r;
  logic [49:0]        lim_prod;
  logic [47:0]        up_prod;
  logic [TimeW-1:0]   cand;
  logic [31:0]        rem_t;
  logic [63:0]        mprod;
  logic [CntW-1:0]    wb, wp;
  logic [CntW:0]      bsum, psum;
  logic [DelayW-1:0]  res_delay;
  logic               res_appr;

  logic [TimeW:0]     diff;
  logic [TimeW-1:0]   elapsed;
  logic [TuneW-1:0]   tune_eff;
  logic [DelayW-1:0]  clamp_hi, clamp_out;
  logic               lim_ok;
  logic               div_done;
  logic [DivNumW-1:0] div_num, div_q;
  logic [DivDenW-1:0] div_den;

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [AmountW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {{(CntW-AmountW+1){1'b0}}, b};
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

  // backups >= ceil(primaries * ratio / 2^16)
  function automatic logic limit_hit(input logic [32:0] b, input logic [49:0] prod);
    logic [50:0] sum;
    sum = {1'b0, prod} + 51'd65535;
    return {2'b0, b} >= sum[50:16];
  endfunction

  assign diff     = {1'b0, now_r} - {1'b0, window_start};
  assign elapsed  = diff[TimeW] ? '0 : diff[TimeW-1:0];
  assign tune_eff = (tune == '0) ? TuneUnity : tune;
  assign clamp_hi = (cand > {8'd0, max_d}) ? max_d : cand[DelayW-1:0];
  assign clamp_out = (clamp_hi < min_d) ? min_d : clamp_hi;
  assign lim_ok   = !limit_hit(bsum, lim_prod);

  assign stat.bypass      = ratio == RatioOne;
  assign stat.roll_needed = elapsed > {8'd0, tick};
  assign stat.roll_up     = limit_hit({1'b0, att_now}, lim_prod);
  assign stat.act1        = act_r;
  assign stat.wt_zero     = elapsed >= {8'd0, tick};
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid || out_ready;

  assign div_num = cmd.div_sel ? mprod : {24'd0, cur_delay, 8'd0};
  assign div_den = cmd.div_sel ? tick  : {16'd0, tune_eff};

  ahrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RatioReset;
      tick  <= TickReset;
      tune  <= TuneReset;
      min_d <= MinDelayReset;
      max_d <= MaxDelayReset;
    end else if (cfg_valid) begin
      case (ahrl_reg_t'(cfg_index))
        REG_BACKUP_RATIO: ratio <= cfg_data[RatioW-1:0];
        REG_TICK_PERIOD:  tick  <= cfg_data;
        REG_TUNE_FACTOR:  tune  <= cfg_data[TuneW-1:0];
        REG_MIN_DELAY:    min_d <= cfg_data;
        REG_MAX_DELAY:    max_d <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      cur_delay    <= MaxDelayReset;
      prim_now     <= '0;
      att_now      <= '0;
      bak_now      <= '0;
      prim_bef     <= '0;
      bak_bef      <= '0;
    end else begin
      if (cmd.roll_commit) begin
        cur_delay    <= clamp_out;
        window_start <= now_r;
        prim_bef     <= prim_now;
        bak_bef      <= bak_now;
        prim_now     <= '0;
        att_now      <= '0;
        bak_now      <= '0;
      end
      if (cmd.act && !act_r) begin
        prim_now <= sat_add(prim_now, amt_r);
      end
      if (cmd.lim_dec) begin
        att_now <= sat_add(att_now, amt_r);
        if (lim_ok) bak_now <= sat_add(bak_now, amt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_action;
      amt_r <= in_amount;
      now_r <= in_now_us;
    end
    if (cmd.bypass_res) begin
      res_delay <= '0;
      res_appr  <= 1'b1;
    end
    if (cmd.roll_mul) begin
      lim_prod <= {18'd0, prim_now} * {33'd0, ratio};
      up_prod  <= {16'd0, cur_delay} * {32'd0, tune_eff};
    end
    if (cmd.roll_dec)     cand <= up_prod[47:8];
    if (cmd.roll_div_cap) cand <= div_q[TimeW-1:0];
    if (cmd.act) begin
      // elapsed is below tick here unless the weight is zero
      rem_t <= tick - elapsed[31:0];
      if (act_r) begin
        wb        <= '0;
        wp        <= '0;
        res_delay <= '0;
      end else begin
        res_delay <= cur_delay;
        res_appr  <= 1'b0;
      end
    end
    if (cmd.w_mul) begin
      mprod <= {32'd0, (cmd.w_sel ? prim_bef : bak_bef)} * {32'd0, rem_t};
    end
    if (cmd.w_cap) begin
      if (cmd.w_sel) wp <= div_q[CntW-1:0];
      else           wb <= div_q[CntW-1:0];
    end
    if (cmd.lim_sum) begin
      bsum <= {1'b0, bak_now}  + {1'b0, wb};
      psum <= {1'b0, prim_now} + {1'b0, wp};
    end
    if (cmd.lim_mul) lim_prod <= {17'd0, psum} * {33'd0, ratio};
    if (cmd.lim_dec) res_appr <= lim_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_delay_us <= res_delay;
      out_approved <= res_appr;
    end
  end

endmodule

// ===== hw/rtl/ahrl_checker.sv =====
// Port-level checks for the rate limiter, bound to the top level.
`include "assert_macros.svh"

module ahrl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [ahrl_pkg::DelayW-1:0] rsp_delay_us,
  input logic                        rsp_approved
);
  import ahrl_pkg::*;

  // stalled response word holds
  `AST_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
            rsp_valid && $stable(rsp_delay_us) && $stable(rsp_approved))

  // one word in flight: ready drops right after an accept
  `AST_NEXT(a_one_inflight, req_valid && req_ready, !req_ready)

  // an approval never carries a delay
  `AST_SAME(a_appr_no_delay, rsp_valid && rsp_approved, rsp_delay_us == '0)

  // a new result is loaded only while the block is busy with a word
  `AST_SAME(a_rsp_from_work, $rose(rsp_valid), !$past(req_ready))

endmodule

bind adaptive_hedging_rate_limiter ahrl_checker u_ahrl_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_delay_us (rsp.delay_us),
  .rsp_approved (rsp.approved)
);
